// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while reset is applied
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a rising edge of clk
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/iap_pkg.sv -----
// ----------------------------------------------------------------------------
// iap_pkg
// types and constants of the integer alu with power
// ----------------------------------------------------------------------------
package iap_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_POW = 3'd4;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [DATA_W-1:0] left_operand;
		logic signed [DATA_W-1:0] right_operand;
	} alu_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     div_by_zero;
	} alu_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/integer_alu_with_power.sv -----
// ----------------------------------------------------------------------------
// integer_alu_with_power
// add, subtract, multiply, truncating divide and power on signed words,
// all wrapping modulo 2^32, built around one shared multiply / subtract unit
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             item
//  req       in         req_valid/req_ready   alu_req_t  (mode, operands)
//  rsp       out        rsp_valid/rsp_ready   alu_rsp_t  (result, div flag)
//
// one item at a time: req_ready is high only while the sequencer is idle
// steps per item: add, subtract, unused codes, divide by zero, zero or negative
// exponent go straight to the final state; multiply runs its step once; divide
// one quotient bit a cycle; power one step per exponent bit up to the top set one
// a result waiting on rsp_ready holds the sequencer in its final state
// arst_n clears the sequencer and the result valid flag, nothing else
// ----------------------------------------------------------------------------
module integer_alu_with_power
	import iap_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  alu_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output alu_rsp_t rsp
);

	// sequencer
	state_t state_q, state_d;

	// working registers, shared between the operations
	// acc_q: running product, quotient, or final value
	// sq_q : squared base, multiplier operand, divisor magnitude
	// exp_q: exponent bits left, dividend bits still to shift in
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sq_q;
	logic [DATA_W-1:0] exp_q;
	logic [DATA_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              dz_q;

	// result register and its valid flag
	alu_rsp_t rsp_q;
	logic     rsp_valid_q;

	logic accept;
	logic rsp_load;

	// shared unit: two independent low-half products for a square-and-multiply
	// step, and one trial subtraction for restoring division
	logic [DATA_W-1:0] prod_acc;
	logic [DATA_W-1:0] prod_sq;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;
	logic              q_bit;
	logic [DATA_W-1:0] q_next;
	logic [DATA_W-1:0] mag_left;
	logic [DATA_W-1:0] mag_right;

	assign prod_acc = acc_q * sq_q;
	assign prod_sq  = sq_q * sq_q;
	assign shifted  = {rem_q, exp_q[DATA_W-1]};
	assign diff     = {1'b0, shifted} - {2'b00, sq_q};
	assign q_bit    = ~diff[DATA_W+1];
	assign q_next   = {acc_q[DATA_W-2:0], q_bit};

	// operand magnitudes; the most negative value maps to 2^(DATA_W-1) unsigned
	assign mag_left  = req.left_operand[DATA_W-1] ?
		(DATA_W)'(-req.left_operand) : req.left_operand;
	assign mag_right = req.right_operand[DATA_W-1] ?
		(DATA_W)'(-req.right_operand) : req.right_operand;

	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.mode)
						MODE_MUL: state_d = ST_MUL;
						MODE_DIV: begin
							// zero divisor goes straight to the result
							state_d = (req.right_operand == '0) ? ST_DONE : ST_DIV;
						end
						MODE_POW: begin
							// negative or zero exponent needs no steps
							if (req.right_operand[DATA_W-1] || req.right_operand == '0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_MUL;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL: begin
				// stop once no set exponent bits remain
				if (exp_q[DATA_W-1:1] == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the result register to be free
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			dz_q <= 1'b0;
			case (req.mode)
				MODE_ADD: acc_q <= req.left_operand + req.right_operand;
				MODE_SUB: acc_q <= req.left_operand - req.right_operand;
				MODE_MUL: begin
					// one multiply step with the exponent bit set
					acc_q <= req.left_operand;
					sq_q  <= req.right_operand;
					exp_q <= (DATA_W)'(1);
				end
				MODE_DIV: begin
					if (req.right_operand == '0) begin
						acc_q <= '0;
						dz_q  <= 1'b1;
					end else begin
						acc_q <= '0;
						rem_q <= '0;
						exp_q <= mag_left;
						sq_q  <= mag_right;
						neg_q <= req.left_operand[DATA_W-1] ^ req.right_operand[DATA_W-1];
						cnt_q <= (CNT_W)'(DATA_W - 1);
					end
				end
				MODE_POW: begin
					if (req.right_operand[DATA_W-1]) begin
						acc_q <= '0;
					end else begin
						acc_q <= (DATA_W)'(1);
						sq_q  <= req.left_operand;
						exp_q <= req.right_operand;
					end
				end
				default: acc_q <= '0;
			endcase
		end else begin
			case (state_q)
				ST_MUL: begin
					if (exp_q[0]) begin
						acc_q <= prod_acc;
					end
					sq_q  <= prod_sq;
					exp_q <= exp_q >> 1;
				end
				ST_DIV: begin
					rem_q <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
					exp_q <= exp_q << 1;
					cnt_q <= cnt_q - 1'b1;
					// sign fix on the last quotient bit
					if (cnt_q == '0) begin
						acc_q <= neg_q ? (DATA_W)'(-q_next) : q_next;
					end else begin
						acc_q <= q_next;
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						rsp_q.result_value <= acc_q;
						rsp_q.div_by_zero  <= dz_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// checks
	`include "assert_macros.svh"

	`ASSERT_CLK(a_dz_zero, rsp_valid && rsp.div_by_zero |-> rsp.result_value == '0, "div by zero result not zero")
	`ASSERT_CLK(a_busy_after_accept, req_valid && req_ready |=> state_q != ST_IDLE, "sequencer idle after accept")
	`ASSERT_NEVER(a_mul_exp, state_q == ST_MUL && exp_q == '0, "multiply step with no exponent bits")

endmodule

// ----- tb/integer_alu_with_power_tb.sv -----
// ----------------------------------------------------------------------------
// integer_alu_with_power_tb
// self-checking bench for the integer alu with power: a directed set of
// corner cases, then random operations, each checked against an in-bench
// model of the arithmetic, with random idling on both handshakes
// ----------------------------------------------------------------------------
module integer_alu_with_power_tb
	import iap_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// codes the block does not use, must give zero and no flag
	localparam logic [2:0] MODE_RSV0 = 3'd5;
	localparam logic [2:0] MODE_RSV1 = 3'd6;
	localparam logic [2:0] MODE_RSV2 = 3'd7;

	localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] WORD_MAX = ~WORD_MIN;
	localparam logic [DATA_W-1:0] WORD_M1  = '1;

	localparam int RANDOM_ITEMS = 1600;
	localparam int QUIET_TAIL   = 250;
	// allows for the slowest item plus the longest idle gap and result stall
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 600000;

	// ------------------------------------------------------------------------
	// scoreboard: predicts each accepted item and checks results in order
	// ------------------------------------------------------------------------
	class alu_scoreboard;
		typedef struct {
			alu_req_t op;
			alu_rsp_t want;
		} awaited_t;

		awaited_t awaited_results[$];
		int       mismatch_count;

		// works out the result of one operation and queues it
		function void note_operation(alu_req_t op);
			logic [DATA_W-1:0] a, b, mag_a, mag_b, quot, acc, sq;
			awaited_t          entry;
			int                bit_idx;
			a = op.left_operand;
			b = op.right_operand;
			entry.op = op;
			entry.want = '0;
			case (op.mode)
				MODE_ADD: entry.want.result_value = a + b;
				MODE_SUB: entry.want.result_value = a - b;
				MODE_MUL: entry.want.result_value = a * b;
				MODE_DIV: begin
					if (b == '0) begin
						entry.want.div_by_zero = 1'b1;
					end else begin
						// truncate toward zero on magnitudes, min / -1 wraps back to min
						mag_a = a[DATA_W-1] ? -a : a;
						mag_b = b[DATA_W-1] ? -b : b;
						quot = mag_a / mag_b;
						entry.want.result_value = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quot : quot;
					end
				end
				MODE_POW: begin
					// negative exponent stays zero, exponent zero gives one
					if (!b[DATA_W-1]) begin
						acc = 1;
						sq = a;
						for (bit_idx = 0; bit_idx < DATA_W; bit_idx++) begin
							if (b[bit_idx])
								acc = acc * sq;
							sq = sq * sq;
						end
						entry.want.result_value = acc;
					end
				end
				default: ;
			endcase
			awaited_results.push_back(entry);
		endfunction

		function void check_result(alu_rsp_t got);
			awaited_t head;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with none awaited: value %0d div_by_zero %0b",
						got.result_value, got.div_by_zero);
				return;
			end
			head = awaited_results.pop_front();
			if (got.result_value !== head.want.result_value ||
					got.div_by_zero !== head.want.div_by_zero) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("mismatch mode %0d a %0d b %0d: expected %0d/%0b got %0d/%0b",
						head.op.mode, head.op.left_operand, head.op.right_operand,
						head.want.result_value, head.want.div_by_zero,
						got.result_value, got.div_by_zero);
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	alu_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	alu_rsp_t rsp;

	alu_scoreboard sb = new;
	bit            idle_on = 1'b1;
	int            cycle_count = 0;

	integer_alu_with_power i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// watchdog, covers a hung handshake as well as a lost result
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// both handshakes sampled on the edge itself, all drives are nonblocking
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready)
			sb.note_operation(req);
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_result(rsp);
	end

	// result side back-pressure: random stall bursts while idling is on
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	function automatic alu_req_t make_op(logic [2:0] mode, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		alu_req_t op;
		op.mode = mode;
		op.left_operand = a;
		op.right_operand = b;
		return op;
	endfunction

	// operand mix: full range words, small values, extremes and powers of two
	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom_range(0, 32) - 16;
			7: begin
				case ($urandom_range(0, 4))
					0:       return WORD_MIN;
					1:       return WORD_MAX;
					2:       return '0;
					3:       return WORD_M1;
					default: return 1;
				endcase
			end
			8:          return {{(DATA_W-1){1'b0}}, 1'b1} << $urandom_range(0, DATA_W-1);
			default:    return $urandom_range(0, 64);
		endcase
	endfunction

	function automatic alu_req_t random_operation();
		alu_req_t op;
		int       pick;
		pick = $urandom_range(0, 99);
		op.left_operand = random_word();
		op.right_operand = random_word();
		if (pick < 18) begin
			op.mode = MODE_ADD;
		end else if (pick < 36) begin
			op.mode = MODE_SUB;
		end else if (pick < 54) begin
			op.mode = MODE_MUL;
		end else if (pick < 76) begin
			op.mode = MODE_DIV;
			// zero divisor now and then on top of what the operand mix gives
			if ($urandom_range(0, 15) == 0)
				op.right_operand = '0;
		end else if (pick < 96) begin
			op.mode = MODE_POW;
			// mostly short exponents, the rest from the operand mix incl. negatives
			if ($urandom_range(0, 3) != 0)
				op.right_operand = $urandom_range(0, DATA_W + 8);
		end else begin
			op.mode = 3'($urandom_range(MODE_RSV0, MODE_RSV2));
		end
		return op;
	endfunction

	// holds valid until accepted; a gap lowers valid at the accepting edge
	task automatic send_item(alu_req_t op);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req <= op;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases: wrap on every operation, divide by zero,
		// min over minus one, truncation of negative quotients, zero and
		// negative exponents, longest exponent and the unused codes
		send_item(make_op(MODE_ADD, WORD_MAX, 1));
		send_item(make_op(MODE_ADD, WORD_MIN, WORD_M1));
		send_item(make_op(MODE_SUB, WORD_MIN, 1));
		send_item(make_op(MODE_SUB, '0, WORD_MIN));
		send_item(make_op(MODE_MUL, WORD_MAX, WORD_MAX));
		send_item(make_op(MODE_MUL, WORD_MIN, WORD_M1));
		send_item(make_op(MODE_MUL, -3, 7));
		send_item(make_op(MODE_DIV, 7, '0));
		send_item(make_op(MODE_DIV, WORD_MIN, WORD_M1));
		send_item(make_op(MODE_DIV, -7, 2));
		send_item(make_op(MODE_DIV, 7, -2));
		send_item(make_op(MODE_DIV, '0, -5));
		send_item(make_op(MODE_DIV, WORD_MAX, WORD_MIN));
		send_item(make_op(MODE_DIV, WORD_MIN, WORD_MIN));
		send_item(make_op(MODE_POW, '0, '0));
		send_item(make_op(MODE_POW, -5, WORD_M1));
		send_item(make_op(MODE_POW, 2, DATA_W - 1));
		send_item(make_op(MODE_POW, WORD_M1, WORD_MAX));
		send_item(make_op(MODE_POW, 3, WORD_MAX));
		send_item(make_op(MODE_POW, WORD_MIN, 2));
		send_item(make_op(MODE_POW, '0, 7));
		send_item(make_op(MODE_RSV0, WORD_MAX, WORD_MAX));
		send_item(make_op(MODE_RSV1, 5, '0));
		send_item(make_op(MODE_RSV2, WORD_M1, WORD_MIN));

		// random part: a quiet stretch in the middle and no idling at the end
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = !((n >= 500 && n < 700) || n >= RANDOM_ITEMS - QUIET_TAIL);
			send_item(random_operation());
		end
		req_valid <= 1'b0;
		@(posedge clk);

		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		// let any stray late result show up
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.awaited_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
